### hdl/mhe_pkg.sv
`default_nettype none

package mhe_pkg;

    // Request kinds carried in the slave-side tuser field.
    localparam logic [1:0] REQ_UINT  = 2'd0;
    localparam logic [1:0] REQ_BIN   = 2'd1;
    localparam logic [1:0] REQ_ARRAY = 2'd2;
    localparam logic [1:0] REQ_NIL   = 2'd3;

    // MessagePack format bytes.
    localparam logic [7:0] FMT_UINT8    = 8'hCC;
    localparam logic [7:0] FMT_UINT16   = 8'hCD;
    localparam logic [7:0] FMT_UINT32   = 8'hCE;
    localparam logic [7:0] FMT_UINT64   = 8'hCF;
    localparam logic [7:0] FMT_BIN8     = 8'hC4;
    localparam logic [7:0] FMT_BIN16    = 8'hC5;
    localparam logic [7:0] FMT_BIN32    = 8'hC6;
    localparam logic [7:0] FMT_ARRAY16  = 8'hDC;
    localparam logic [7:0] FMT_ARRAY32  = 8'hDD;
    localparam logic [3:0] FMT_FIXARRAY = 4'h9;
    // Nil goes out as an empty fixarray.
    localparam logic [7:0] FMT_NIL      = 8'h90;

    // Longest sequence: one format byte plus eight payload bytes.
    localparam int unsigned FRM_BYTES = 9;
    localparam int unsigned FRM_W     = FRM_BYTES * 8;
    localparam int unsigned CNT_W     = $clog2(FRM_BYTES + 1);

    // One encoded sequence, first byte in the top bits.
    typedef struct packed {
        logic             valid;
        logic [FRM_W-1:0] bytes;
        logic [CNT_W-1:0] count;
    } t_frame;

endpackage

`default_nettype wire

### hdl/msgpack_header_encoder.sv
// MessagePack header encoder.
// Slave channel: one transaction is one request. tuser carries the kind
// (unsigned integer, binary header, array header, nil) and tdata the
// 64-bit value or size. Master channel: one transaction per encoded byte,
// tlast set on the final byte of each request's sequence.
// A request turns into 1 to 9 bytes: positive fixint, fixarray and nil take
// one, uint64 takes nine. The master port moves one byte per cycle while the
// receiver holds tready high, and requests follow each other with no gap in
// the byte stream.
// The first byte passes through the input register, then the shift buffer,
// then the output register before it is presented.
// The input register is refilled in the cycle the shift buffer picks up its
// frame, so a new request is taken while the previous one is still draining.
// When the receiver holds tready low, the output byte holds, the shift
// buffer and input register fill, and then tready on the slave side drops.
// Reset (synchronous, active low) empties all stages; no byte is
// presented, and a fresh request is taken as soon as reset is released.
`default_nettype none

module msgpack_header_encoder
    import mhe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // value[63:0]
    input  wire logic [1:0]  i_s_axis_tuser,   // req_type[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // out_byte[7:0]
    output logic             o_m_axis_tlast    // last
);

    t_frame frm;
    logic   take;

    mhe_encode u_encode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_take          (take),
        .o_frm           (frm)
    );

    mhe_serializer u_serializer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frm           (frm),
        .o_take          (take),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // The serializer only picks up a frame that the encoder holds.
    a_take_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> frm.valid)
        else $error("frame taken while encoder stage empty");

    // Every encoded frame has one of the legal MessagePack lengths.
    a_frame_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frm.valid |-> (frm.count == CNT_W'(1)) || (frm.count == CNT_W'(2)) ||
                      (frm.count == CNT_W'(3)) || (frm.count == CNT_W'(5)) ||
                      (frm.count == CNT_W'(9)))
        else $error("illegal frame length");

    // Reset leaves no byte on the master side.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled slave side means the input register holds a request.
    a_stall_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> frm.valid && !take)
        else $error("slave stalled with no pending request");

endmodule

`default_nettype wire

### hdl/mhe_encode.sv
`default_nettype none

module mhe_encode
    import mhe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // value[63:0]
    input  wire logic [1:0]  i_s_axis_tuser,   // req_type[1:0]
    input  wire logic        i_take,
    output t_frame           o_frm
);

    logic        r_valid;
    logic [1:0]  r_type;
    logic [63:0] r_value;
    logic        n_valid;
    logic        accept;

    // The input register frees up in the same cycle the serializer takes its frame.
    assign o_s_axis_tready = !r_valid || i_take;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_take) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type  <= i_s_axis_tuser;
            r_value <= i_s_axis_tdata;
        end
    end

    // Range tests on the registered value.
    logic fits7, fits4, fits8, fits16, fits32;
    assign fits4  = (r_value[63:4]  == '0);
    assign fits7  = (r_value[63:7]  == '0);
    assign fits8  = (r_value[63:8]  == '0);
    assign fits16 = (r_value[63:16] == '0);
    assign fits32 = (r_value[63:32] == '0);

    // Pick the shortest form and left-align format byte and big-endian payload.
    always_comb begin
        o_frm.valid = r_valid;
        o_frm.bytes = {FMT_NIL, 64'd0};
        o_frm.count = CNT_W'(1);
        case (r_type)
            REQ_UINT: begin
                if (fits7) begin
                    o_frm.bytes = {r_value[7:0], 64'd0};
                    o_frm.count = CNT_W'(1);
                end else if (fits8) begin
                    o_frm.bytes = {FMT_UINT8, r_value[7:0], 56'd0};
                    o_frm.count = CNT_W'(2);
                end else if (fits16) begin
                    o_frm.bytes = {FMT_UINT16, r_value[15:0], 48'd0};
                    o_frm.count = CNT_W'(3);
                end else if (fits32) begin
                    o_frm.bytes = {FMT_UINT32, r_value[31:0], 32'd0};
                    o_frm.count = CNT_W'(5);
                end else begin
                    o_frm.bytes = {FMT_UINT64, r_value};
                    o_frm.count = CNT_W'(9);
                end
            end
            REQ_BIN: begin
                if (fits8) begin
                    o_frm.bytes = {FMT_BIN8, r_value[7:0], 56'd0};
                    o_frm.count = CNT_W'(2);
                end else if (fits16) begin
                    o_frm.bytes = {FMT_BIN16, r_value[15:0], 48'd0};
                    o_frm.count = CNT_W'(3);
                end else begin
                    // Sizes beyond 32 bits keep only their low word.
                    o_frm.bytes = {FMT_BIN32, r_value[31:0], 32'd0};
                    o_frm.count = CNT_W'(5);
                end
            end
            REQ_ARRAY: begin
                if (fits4) begin
                    o_frm.bytes = {FMT_FIXARRAY, r_value[3:0], 64'd0};
                    o_frm.count = CNT_W'(1);
                end else if (fits16) begin
                    o_frm.bytes = {FMT_ARRAY16, r_value[15:0], 48'd0};
                    o_frm.count = CNT_W'(3);
                end else begin
                    o_frm.bytes = {FMT_ARRAY32, r_value[31:0], 32'd0};
                    o_frm.count = CNT_W'(5);
                end
            end
            default: begin
                // Nil ignores the value.
                o_frm.bytes = {FMT_NIL, 64'd0};
                o_frm.count = CNT_W'(1);
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/mhe_serializer.sv
`default_nettype none

module mhe_serializer
    import mhe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_frame     i_frm,
    output logic            o_take,
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // out_byte[7:0]
    output logic            o_m_axis_tlast    // last
);

    logic [FRM_W-1:0] r_buf;
    logic [FRM_W-1:0] n_buf;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [7:0]       r_out_byte;
    logic [7:0]       n_out_byte;
    logic             r_out_last;
    logic             n_out_last;
    logic             can_out;
    logic             move;
    logic             frm_free;

    // A buffered byte goes to the output register if that register is empty or drained.
    assign can_out  = !r_out_valid || i_m_axis_tready;
    assign move     = (r_cnt != '0) && can_out;
    assign frm_free = (r_cnt == '0) || (move && (r_cnt == CNT_W'(1)));
    assign o_take   = frm_free && i_frm.valid;

    // Shift buffer: the next byte is always in the top lane.
    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (move) begin
            n_buf = {r_buf[FRM_W-9:0], 8'h00};
            n_cnt = r_cnt - CNT_W'(1);
        end
        if (o_take) begin
            n_buf = i_frm.bytes;
            n_cnt = i_frm.count;
        end
    end

    // Output register.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (can_out) begin
            n_out_valid = move;
            n_out_byte  = r_buf[FRM_W-1 -: 8];
            n_out_last  = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf      <= n_buf;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
